/* rtl/gvf_pkg.sv */
// shared types, widths and codes of the garch variance filter
package gvf_pkg;

  localparam int RES_W      = 32;
  localparam int VAR_W      = 48;
  localparam int COEF_W     = 16;
  localparam int SQ_W       = 64;
  localparam int ACC_W      = 64;
  localparam int HALF_W     = 16;
  localparam int NUM_COEFFS = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int POS_W      = 2;
  localparam int SUM_W      = 19;
  localparam int DEN_W      = 17;
  localparam int DIV_NUM_W  = 64;
  localparam int FRAC_W     = 16;

  localparam int DEF_MAX_ARCH_LAGS  = 3;
  localparam int DEF_MAX_GARCH_LAGS = 3;

  localparam logic [VAR_W-1:0] VAR_MAX = '1;
  localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] LAG_ORDER_RST = POS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OMEGA,
    REG_ARCH_1,
    REG_ARCH_2,
    REG_ARCH_3,
    REG_GARCH_1,
    REG_GARCH_2,
    REG_GARCH_3,
    REG_LAG_ORDER
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SH_R0,
    SH_R16,
    SH_R32,
    SH_L16
  } shift_op_t;

  typedef struct packed {
    logic signed [RES_W-1:0] residual;
    logic [VAR_W-1:0]        initial_variance;
    logic                    has_initial;
    logic                    series_start;
  } in_item_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             nonstationary;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic             load;
    logic [ACC_W-1:0] init;
    logic             mul;
    logic [COEF_W-1:0] a;
    logic [VAR_W-1:0] b;
    shift_op_t        shift;
  } mac_cmd_t;

endpackage

/* rtl/gvf_chan_if.sv */
// valid/ready channel carrying one payload per transfer
interface gvf_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gvf_mac.sv */
// shared multiply-accumulate unit with registered product and shifted accumulate
module gvf_mac (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gvf_pkg::mac_cmd_t        cmd,
  output logic [gvf_pkg::ACC_W-1:0] acc
);
  import gvf_pkg::*;

  logic [ACC_W-1:0] prod_r;
  shift_op_t        shift_r;
  logic             prod_vld_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] term;

  always_comb begin
    case (shift_r)
      SH_R0:   term = prod_r;
      SH_R16:  term = prod_r >> 16;
      SH_R32:  term = prod_r >> 32;
      SH_L16:  term = prod_r << 16;
      default: term = prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= cmd.mul;
      if (cmd.load) begin
        acc_r <= cmd.init;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + term;
      end
    end
    if (cmd.mul) begin
      prod_r  <= ACC_W'(cmd.a) * ACC_W'(cmd.b);
      shift_r <= cmd.shift;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/gvf_div.sv */
// restoring divider, one quotient bit per cycle
module gvf_div #(
  parameter int NUM_W = gvf_pkg::DIV_NUM_W,
  parameter int DEN_W = gvf_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import gvf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* rtl/garch_variance_filter.sv */
// top level of the garch(p,q) conditional variance filter
// One residual goes in and one conditional variance comes out per transfer. An item that runs
// the recursion squares its residual, then multiplies the used ARCH and GARCH terms into the
// accumulator; warm-up and nonstationary items skip the recursion. The first item of a series
// with a coefficient sum below one also waits for the one-bit-per-cycle divider that forms the
// long-run variance over a 64-bit dividend. Input is accepted again from the cycle after the
// result is registered. All products, the residual square included, go one at a time through a
// single 16 x 48 multiplier followed by a 64-bit accumulator. Input is not taken while an item
// is in progress; a finished result waits in the output register so the next item can enter,
// and an item whose result finds that register still full holds until it drains.
// Configuration writes take effect at once and are meant for idle periods only.
module garch_variance_filter #(
  parameter int MAX_ARCH_LAGS  = gvf_pkg::DEF_MAX_ARCH_LAGS,
  parameter int MAX_GARCH_LAGS = gvf_pkg::DEF_MAX_GARCH_LAGS
) (
  input  logic       clk,
  input  logic       rst_n,
  gvf_chan_if.sink   in_chan,
  gvf_chan_if.source out_chan,
  gvf_chan_if.sink   cfg_chan
);
  import gvf_pkg::*;

  localparam int ARCH_USED  = (MAX_ARCH_LAGS < NUM_COEFFS) ? MAX_ARCH_LAGS : NUM_COEFFS;
  localparam int GARCH_USED = (MAX_GARCH_LAGS < NUM_COEFFS) ? MAX_GARCH_LAGS : NUM_COEFFS;
  localparam int NSTEPS     = 2 * ARCH_USED + GARCH_USED;
  localparam int STEP_W     = $clog2(NSTEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_DRAIN,
    S_SQ_SAVE,
    S_DIV,
    S_DECIDE,
    S_REC_MUL,
    S_REC_DRAIN,
    S_REC_SAVE,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [VAR_W-1:0]  omega_r;
  logic [COEF_W-1:0] arch_c_r  [NUM_COEFFS];
  logic [COEF_W-1:0] garch_c_r [NUM_COEFFS];
  logic [POS_W-1:0]  lag_r;

  // history and series state
  logic [SQ_W-1:0]  sq_hist_r  [MAX_ARCH_LAGS];
  logic [VAR_W-1:0] var_hist_r [MAX_GARCH_LAGS];
  logic [POS_W-1:0] pos_r;
  logic [VAR_W-1:0] lrv_r;

  // item working registers
  logic [RES_W-1:0]  mag_r;
  logic [VAR_W-1:0]  init_r;
  logic              has_init_r;
  logic [SQ_W-1:0]   sq_r;
  logic [VAR_W-1:0]  var_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [COEF_W-1:0] arch_use  [NUM_COEFFS];
  logic [COEF_W-1:0] garch_use [NUM_COEFFS];
  logic [SUM_W-1:0]  coef_sum;
  logic              nonstat;
  logic [DEN_W-1:0]  den;
  logic [RES_W-1:0]  res_u;
  logic [RES_W-1:0]  mag;
  logic              in_fire;
  mac_cmd_t          mac_cmd;
  logic [ACC_W-1:0]  mac_acc;
  logic              div_start;
  logic              div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [VAR_W-1:0]  lrv_sat;

  // coefficients past lag_order or past the history depth count as zero
  always_comb begin
    coef_sum = '0;
    for (int k = 0; k < NUM_COEFFS; k++) begin
      arch_use[k]  = (k < ARCH_USED && {1'b0, lag_r} > 3'(k)) ? arch_c_r[k] : '0;
      garch_use[k] = (k < GARCH_USED && {1'b0, lag_r} > 3'(k)) ? garch_c_r[k] : '0;
      coef_sum = coef_sum + SUM_W'(arch_use[k]) + SUM_W'(garch_use[k]);
    end
  end

  assign nonstat = coef_sum >= ONE_Q16;
  assign den     = DEN_W'(ONE_Q16 - coef_sum);

  assign res_u   = in_chan.data.residual;
  assign mag     = res_u[RES_W-1] ? (~res_u + 1'b1) : res_u;
  assign in_fire = (state_r == S_IDLE) && in_chan.valid;

  assign lrv_sat = (div_quot[DIV_NUM_W-1:VAR_W] != '0) ? VAR_MAX : div_quot[VAR_W-1:0];

  always_comb begin
    mac_cmd       = '0;
    mac_cmd.shift = SH_R0;
    div_start     = (state_r == S_SQ_SAVE) && (pos_r == '0) && !nonstat;
    if (in_fire) begin
      mac_cmd.load = 1'b1;
    end
    if (state_r == S_DECIDE && !nonstat && !(pos_r < lag_r)) begin
      mac_cmd.load = 1'b1;
      mac_cmd.init = ACC_W'(omega_r);
    end
    if (state_r == S_SQ_MUL) begin
      mac_cmd.mul   = 1'b1;
      mac_cmd.a     = step_r[0] ? mag_r[RES_W-1:HALF_W] : mag_r[HALF_W-1:0];
      mac_cmd.b     = VAR_W'(mag_r);
      mac_cmd.shift = step_r[0] ? SH_L16 : SH_R0;
    end
    if (state_r == S_REC_MUL) begin
      mac_cmd.mul = 1'b1;
      for (int k = 0; k < ARCH_USED; k++) begin
        if (step_r == STEP_W'(2 * k)) begin
          mac_cmd.a     = arch_use[k];
          mac_cmd.b     = VAR_W'(sq_hist_r[k][SQ_W-1:SQ_W/2]);
          mac_cmd.shift = SH_R0;
        end
        if (step_r == STEP_W'(2 * k + 1)) begin
          mac_cmd.a     = arch_use[k];
          mac_cmd.b     = VAR_W'(sq_hist_r[k][SQ_W/2-1:0]);
          mac_cmd.shift = SH_R32;
        end
      end
      for (int k = 0; k < GARCH_USED; k++) begin
        if (step_r == STEP_W'(2 * ARCH_USED + k)) begin
          mac_cmd.a     = garch_use[k];
          mac_cmd.b     = var_hist_r[k];
          mac_cmd.shift = SH_R16;
        end
      end
    end
  end

  gvf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .acc   (mac_acc)
  );

  gvf_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({omega_r, {FRAC_W{1'b0}}}),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      omega_r     <= '0;
      lag_r       <= LAG_ORDER_RST;
      pos_r       <= '0;
      lrv_r       <= '0;
      step_r      <= '0;
      for (int k = 0; k < NUM_COEFFS; k++) begin
        arch_c_r[k]  <= '0;
        garch_c_r[k] <= '0;
      end
      for (int k = 0; k < MAX_ARCH_LAGS; k++) begin
        sq_hist_r[k] <= '0;
      end
      for (int k = 0; k < MAX_GARCH_LAGS; k++) begin
        var_hist_r[k] <= '0;
      end
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.data.index)
          REG_OMEGA:     omega_r      <= cfg_chan.data.wdata[VAR_W-1:0];
          REG_ARCH_1:    arch_c_r[0]  <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_ARCH_2:    arch_c_r[1]  <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_ARCH_3:    arch_c_r[2]  <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_GARCH_1:   garch_c_r[0] <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_GARCH_2:   garch_c_r[1] <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_GARCH_3:   garch_c_r[2] <= cfg_chan.data.wdata[COEF_W-1:0];
          REG_LAG_ORDER: lag_r        <= cfg_chan.data.wdata[POS_W-1:0];
        endcase
      end

      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            mag_r      <= mag;
            init_r     <= in_chan.data.initial_variance;
            has_init_r <= in_chan.data.has_initial;
            step_r     <= '0;
            if (in_chan.data.series_start) begin
              pos_r <= '0;
              for (int k = 0; k < MAX_ARCH_LAGS; k++) begin
                sq_hist_r[k] <= '0;
              end
              for (int k = 0; k < MAX_GARCH_LAGS; k++) begin
                var_hist_r[k] <= '0;
              end
            end
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_r[0]) begin
            state_r <= S_SQ_DRAIN;
          end
        end
        S_SQ_DRAIN: begin
          state_r <= S_SQ_SAVE;
        end
        S_SQ_SAVE: begin
          sq_r <= mac_acc;
          if (pos_r == '0 && !nonstat) begin
            state_r <= S_DIV;
          end else begin
            if (pos_r == '0) begin
              lrv_r <= '0;
            end
            state_r <= S_DECIDE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            lrv_r   <= lrv_sat;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          step_r <= '0;
          if (nonstat) begin
            var_r   <= '0;
            state_r <= S_DONE;
          end else if (pos_r < lag_r) begin
            var_r   <= has_init_r ? init_r : lrv_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_REC_MUL;
          end
        end
        S_REC_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(NSTEPS - 1)) begin
            state_r <= S_REC_DRAIN;
          end
        end
        S_REC_DRAIN: begin
          state_r <= S_REC_SAVE;
        end
        S_REC_SAVE: begin
          var_r   <= (mac_acc[ACC_W-1:VAR_W] != '0) ? VAR_MAX : mac_acc[VAR_W-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.variance      <= var_r;
            out_data_r.nonstationary <= nonstat;
            sq_hist_r[0]             <= sq_r;
            var_hist_r[0]            <= var_r;
            for (int k = 1; k < MAX_ARCH_LAGS; k++) begin
              sq_hist_r[k] <= sq_hist_r[k-1];
            end
            for (int k = 1; k < MAX_GARCH_LAGS; k++) begin
              var_hist_r[k] <= var_hist_r[k-1];
            end
            if (pos_r != POS_MAX) begin
              pos_r <= pos_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign cfg_chan.ready = 1'b1;

endmodule

/* tb/sv/gvf_variance_checker.sv */
`timescale 1ns / 100ps
// checker for the garch variance filter: predicts each conditional variance and compares results
module gvf_variance_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  gvf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  gvf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  gvf_pkg::cfg_item_t cfg_data,
  output int                 mismatch_count,
  output int                 pending_results
);
  import gvf_pkg::*;

  logic [VAR_W-1:0]  omega_q;
  logic [COEF_W-1:0] arch_q [NUM_COEFFS];
  logic [COEF_W-1:0] garch_q [NUM_COEFFS];
  logic [POS_W-1:0]  lag_q;
  logic [SQ_W-1:0]   sq_hist [NUM_COEFFS];
  logic [VAR_W-1:0]  var_hist [NUM_COEFFS];
  logic [POS_W-1:0]  pos_q;
  logic [VAR_W-1:0]  long_run_q;
  out_item_t         expected_variances [$];

  function automatic logic [VAR_W-1:0] clip_variance(logic [ACC_W-1:0] v);
    return (v > ACC_W'(VAR_MAX)) ? VAR_MAX : v[VAR_W-1:0];
  endfunction

  function automatic out_item_t predict_variance(in_item_t item);
    logic [SUM_W-1:0] coef_sum;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sq;
    logic             nonstat;
    out_item_t        res;
    int               k;
    if (item.series_start) begin
      for (k = 0; k < NUM_COEFFS; k++) begin
        sq_hist[k] = '0;
        var_hist[k] = '0;
      end
      pos_q = '0;
    end
    coef_sum = '0;
    for (k = 0; k < NUM_COEFFS; k++) begin
      if (k < int'(lag_q)) coef_sum = coef_sum + SUM_W'(arch_q[k]) + SUM_W'(garch_q[k]);
    end
    nonstat = (coef_sum >= ONE_Q16);
    if (pos_q == '0) begin
      if (nonstat) begin
        long_run_q = '0;
      end else begin
        acc = (ACC_W'(omega_q) << FRAC_W) / ACC_W'(ONE_Q16 - coef_sum);
        long_run_q = clip_variance(acc);
      end
    end
    if (nonstat) begin
      res.variance = '0;
    end else if (pos_q < lag_q) begin
      res.variance = item.has_initial ? item.initial_variance : long_run_q;
    end else begin
      acc = ACC_W'(omega_q);
      for (k = 0; k < NUM_COEFFS; k++) begin
        if (k < int'(lag_q)) begin
          acc = acc + ACC_W'(arch_q[k]) * (sq_hist[k] >> 32)
                + ((ACC_W'(arch_q[k]) * (sq_hist[k] & 64'hFFFF_FFFF)) >> 32);
          acc = acc + ((ACC_W'(garch_q[k]) * ACC_W'(var_hist[k])) >> FRAC_W);
        end
      end
      res.variance = clip_variance(acc);
    end
    res.nonstationary = nonstat;
    // residual square in q32.32 from the magnitude
    if (item.residual[RES_W-1]) mag = 64'h1_0000_0000 - {32'b0, item.residual};
    else mag = {32'b0, item.residual};
    sq = mag * mag;
    for (k = NUM_COEFFS - 1; k > 0; k--) begin
      sq_hist[k] = sq_hist[k-1];
      var_hist[k] = var_hist[k-1];
    end
    sq_hist[0] = sq;
    var_hist[0] = res.variance;
    if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    int        k;
    if (!rst_n) begin
      omega_q = '0;
      lag_q = LAG_ORDER_RST;
      for (k = 0; k < NUM_COEFFS; k++) begin
        arch_q[k] = '0;
        garch_q[k] = '0;
        sq_hist[k] = '0;
        var_hist[k] = '0;
      end
      pos_q = '0;
      long_run_q = '0;
      expected_variances.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_OMEGA:     omega_q = cfg_data.wdata[VAR_W-1:0];
          REG_ARCH_1:    arch_q[0] = cfg_data.wdata[COEF_W-1:0];
          REG_ARCH_2:    arch_q[1] = cfg_data.wdata[COEF_W-1:0];
          REG_ARCH_3:    arch_q[2] = cfg_data.wdata[COEF_W-1:0];
          REG_GARCH_1:   garch_q[0] = cfg_data.wdata[COEF_W-1:0];
          REG_GARCH_2:   garch_q[1] = cfg_data.wdata[COEF_W-1:0];
          REG_GARCH_3:   garch_q[2] = cfg_data.wdata[COEF_W-1:0];
          REG_LAG_ORDER: lag_q = cfg_data.wdata[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_variances.push_back(predict_variance(in_data));
      if (out_valid && out_ready) begin
        if (expected_variances.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got variance %h nonstationary %0b",
                   $time, out_data.variance, out_data.nonstationary);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_variances.pop_front();
          bad = 1'b0;
          if (out_data.variance !== want.variance) begin
            $display("%0t: variance expected %h got %h", $time, want.variance,
                     out_data.variance);
            bad = 1'b1;
          end
          if (out_data.nonstationary !== want.nonstationary) begin
            $display("%0t: nonstationary expected %0b got %0b", $time, want.nonstationary,
                     out_data.nonstationary);
            bad = 1'b1;
          end
          if (bad) mismatch_count <= mismatch_count + 1;
        end
      end
    end
    pending_results <= expected_variances.size();
  end

endmodule

/* tb/sv/tb_garch_variance_filter.sv */
`timescale 1ns / 100ps
// testbench top for the garch variance filter: stimulus, watchdog and verdict
module tb_garch_variance_filter;
  import gvf_pkg::*;

  localparam int CHUNK_ITEMS = 155;
  localparam int CHUNKS_PER_PHASE = 4;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatch_count;
  int   pending_results;
  int   quiet_cycles = 0;

  always #1 clk = ~clk;

  gvf_chan_if #(.T(in_item_t))  in_if ();
  gvf_chan_if #(.T(out_item_t)) out_if ();
  gvf_chan_if #(.T(cfg_item_t)) cfg_if ();

  garch_variance_filter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  gvf_variance_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_data         (in_if.data),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_data        (out_if.data),
    .cfg_valid       (cfg_if.valid),
    .cfg_ready       (cfg_if.ready),
    .cfg_data        (cfg_if.data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[garch_variance_filter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_residual(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.data <= item;
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.data <= cfg_item_t'{idx, val};
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_filter(logic [VAR_W-1:0] om, logic [COEF_W-1:0] a1, a2, a3,
                             logic [COEF_W-1:0] g1, g2, g3, logic [POS_W-1:0] lag);
    wait_drained();
    write_register(REG_OMEGA, om);
    write_register(REG_ARCH_1, CFG_DATA_W'(a1));
    write_register(REG_ARCH_2, CFG_DATA_W'(a2));
    write_register(REG_ARCH_3, CFG_DATA_W'(a3));
    write_register(REG_GARCH_1, CFG_DATA_W'(g1));
    write_register(REG_GARCH_2, CFG_DATA_W'(g2));
    write_register(REG_GARCH_3, CFG_DATA_W'(g3));
    write_register(REG_LAG_ORDER, CFG_DATA_W'(lag));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t          it;
    logic [COEF_W-1:0] coef [6];
    logic [VAR_W-1:0]  om;
    logic [63:0]       wide;
    logic [RES_W-1:0]  r;
    logic [POS_W-1:0]  lag;
    logic              start;
    int                budget, mode, sent, len, k, phase, chunk, sel;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults, first transfer opens a series on its own
    send_residual(in_item_t'{32'sh7FFF_FFFF, VAR_MAX, 1'b1, 1'b0});
    send_residual(in_item_t'{32'sh8000_0000, 48'h0, 1'b0, 1'b0});

    // coefficient sum just below one, long-run variance and recursion saturate
    load_filter(VAR_MAX, 16'd30000, 16'd20000, 16'd10000, 16'd5000, 16'd300, 16'd235, 2'd3);
    send_residual(in_item_t'{32'sh7FFF_FFFF, 48'h0, 1'b0, 1'b1});
    send_residual(in_item_t'{32'sh8000_0000, 48'h0, 1'b1, 1'b0});
    send_residual(in_item_t'{-32'sd1, VAR_MAX, 1'b1, 1'b0});
    send_residual(in_item_t'{32'sh0, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh1, 48'h0, 1'b0, 1'b0});

    // coefficient sum exactly one
    load_filter(48'h1_0000_0000, 16'hFFFF, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 2'd1);
    send_residual(in_item_t'{32'sh0001_0000, 48'h1_0000, 1'b1, 1'b1});
    send_residual(in_item_t'{32'sh7FFF_FFFF, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh8000_0000, 48'h0, 1'b0, 1'b0});

    // no lags used, every coefficient ignored
    load_filter(48'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0);
    send_residual(in_item_t'{32'sh7FFF_FFFF, VAR_MAX, 1'b1, 1'b1});
    send_residual(in_item_t'{32'sh8000_0000, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh0, 48'h0, 1'b0, 1'b0});

    // two lags, third lag weights set high but unused
    load_filter(48'h1_0000, 16'h2000, 16'h1000, 16'hFFFF, 16'h8000, 16'h1800, 16'hFFFF, 2'd2);
    send_residual(in_item_t'{32'sh0001_0000, 48'h2_0000, 1'b1, 1'b1});
    send_residual(in_item_t'{32'shFFFF_0000, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh0002_0000, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh0000_8000, 48'h0, 1'b0, 1'b0});
    send_residual(in_item_t'{32'sh0, 48'h5_0000, 1'b1, 1'b1});

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 24 : 0;
      for (chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
        lag = POS_W'($urandom_range(0, 3));
        mode = $urandom_range(0, 9);
        budget = $urandom_range(0, 65535);
        for (k = 0; k < 6; k++) begin
          if (mode == 0) coef[k] = 16'hFFFF;
          else if (mode == 1) coef[k] = 16'($urandom);
          else coef[k] = 16'($urandom_range(0, budget / 6));
        end
        // weights beyond the lag order get arbitrary values
        for (k = 0; k < 3; k++) begin
          if (k >= lag) begin
            coef[k] = 16'($urandom);
            coef[k+3] = 16'($urandom);
          end
        end
        case ($urandom_range(0, 4))
          0: om = '0;
          1: om = VAR_MAX;
          default: begin
            wide = {$urandom, $urandom};
            om = wide[VAR_W-1:0] >> $urandom_range(0, 32);
          end
        endcase
        load_filter(om, coef[0], coef[1], coef[2], coef[3], coef[4], coef[5], lag);

        sent = 0;
        while (sent < CHUNK_ITEMS) begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len && sent < CHUNK_ITEMS; k++) begin
            start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            r = $urandom;
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
              case ($urandom_range(0, 3))
                0: r = 32'h7FFF_FFFF;
                1: r = 32'h8000_0000;
                2: r = '0;
                default: r = '1;
              endcase
            end else if (sel > 3) begin
              r = $signed(r) >>> $urandom_range(8, 20);
            end
            wide = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) wide = wide >> $urandom_range(16, 56);
            it.residual = r;
            it.initial_variance = wide[VAR_W-1:0];
            it.has_initial = ($urandom_range(0, 2) == 0);
            it.series_start = start;
            send_residual(it);
            sent++;
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[garch_variance_filter] OK");
    end else begin
      $display("[garch_variance_filter] ERROR");
    end
    $finish;
  end

endmodule

/* garch_variance_filter.f */
rtl/gvf_pkg.sv
rtl/gvf_chan_if.sv
rtl/gvf_mac.sv
rtl/gvf_div.sv
rtl/garch_variance_filter.sv
tb/sv/gvf_variance_checker.sv
tb/sv/tb_garch_variance_filter.sv
